// ===== sv/tsq_pkg.sv =====
`timescale 1ns / 1ps
// Package for the two-stack queue: beat payload types, status and command codes,
// register indexes and the handshake structs between the top level and the sequencer.
// Depends on nothing.
package tsq_pkg;

  localparam int VALUE_W   = 32;
  localparam int CAP_W     = 7;
  localparam int REG_IDX_W = 2;

  localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

  localparam logic [REG_IDX_W-1:0] REG_CAP_FIRST  = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_CAP_SECOND = 2'd1;

  localparam logic CMD_ENQ = 1'b0;
  localparam logic CMD_DEQ = 1'b1;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  typedef struct packed {
    logic                      cmd;
    logic signed [VALUE_W-1:0] value;
  } in_item_t;

  typedef struct packed {
    logic [1:0]                status;
    logic signed [VALUE_W-1:0] out_value;
  } out_item_t;

  // Accepted input beat handed to the sequencer.
  typedef struct packed {
    logic     valid;
    in_item_t item;
  } tsq_start_t;

  // Finished result handed back to the output register.
  typedef struct packed {
    logic      done;
    out_item_t item;
  } tsq_res_t;

endpackage

// ===== sv/tsq_ram.sv =====
`timescale 1ns / 1ps
// Single-write, single-read stack memory with registered read data.
// Depends on tsq_pkg for the data width.
module tsq_ram #(
  parameter int DEPTH = 64,
  parameter int AW    = 6
) (
  input  logic                        clk,
  input  logic                        we,
  input  logic [AW-1:0]               waddr,
  input  logic [tsq_pkg::VALUE_W-1:0] wdata,
  input  logic                        re,
  input  logic [AW-1:0]               raddr,
  output logic [tsq_pkg::VALUE_W-1:0] rdata
);

  logic [tsq_pkg::VALUE_W-1:0] mem [0:DEPTH-1];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== sv/tsq_seq.sv =====
`timescale 1ns / 1ps
// Sequencer for the two-stack queue: stack counts, the transfer loop and both stack memories.
// Depends on tsq_pkg and tsq_ram.
module tsq_seq #(
  parameter int STACK_DEPTH = 64,
  parameter int CW          = 7,
  parameter int AW          = 6
) (
  input  logic                clk,
  input  logic                rst,
  input  tsq_pkg::tsq_start_t start,
  input  logic [CW-1:0]       bound,
  input  logic                out_free,
  output logic                busy,
  output tsq_pkg::tsq_res_t   res
);

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_MOVE   = 2'd1;
  localparam logic [1:0] S_READ   = 2'd2;
  localparam logic [1:0] S_FINISH = 2'd3;

  logic [1:0]                  state, state_next;
  logic [CW-1:0]               in_count, in_count_next;
  logic [CW-1:0]               out_count, out_count_next;
  logic                        cmd, cmd_next;
  logic [tsq_pkg::VALUE_W-1:0] value, value_next;
  logic [1:0]                  res_status, res_status_next;
  logic [tsq_pkg::VALUE_W-1:0] res_value, res_value_next;
  logic                        pend, pend_next;

  logic [CW-1:0]               in_dec, out_dec;
  logic                        in_we, in_re, out_we, out_re;
  logic [AW-1:0]               in_waddr, in_raddr, out_waddr, out_raddr;
  logic [tsq_pkg::VALUE_W-1:0] in_wdata, out_wdata, in_rdata, out_rdata;

  assign in_dec  = in_count - CW'(1);
  assign out_dec = out_count - CW'(1);

  tsq_ram #(.DEPTH(STACK_DEPTH), .AW(AW)) u_in_ram (
    .clk(clk), .we(in_we), .waddr(in_waddr), .wdata(in_wdata),
    .re(in_re), .raddr(in_raddr), .rdata(in_rdata)
  );

  tsq_ram #(.DEPTH(STACK_DEPTH), .AW(AW)) u_out_ram (
    .clk(clk), .we(out_we), .waddr(out_waddr), .wdata(out_wdata),
    .re(out_re), .raddr(out_raddr), .rdata(out_rdata)
  );

  always_comb begin
    state_next      = state;
    in_count_next   = in_count;
    out_count_next  = out_count;
    cmd_next        = cmd;
    value_next      = value;
    res_status_next = res_status;
    res_value_next  = res_value;
    pend_next       = 1'b0;
    in_we     = 1'b0;
    in_waddr  = in_count[AW-1:0];
    in_wdata  = value;
    in_re     = 1'b0;
    in_raddr  = in_dec[AW-1:0];
    out_we    = 1'b0;
    out_waddr = out_count[AW-1:0];
    out_wdata = in_rdata;
    out_re    = 1'b0;
    out_raddr = out_dec[AW-1:0];
    res.done  = 1'b0;
    res.item.status    = res_status;
    res.item.out_value = res_value;

    unique case (state)
      S_IDLE: begin
        if (start.valid) begin
          cmd_next   = start.item.cmd;
          value_next = start.item.value;
          if (start.item.cmd == tsq_pkg::CMD_ENQ) begin
            if (in_count < bound) begin
              in_we         = 1'b1;
              in_wdata      = start.item.value;
              in_count_next = in_count + CW'(1);
            end else if (out_count == '0 && bound != '0) begin
              state_next = S_MOVE;
            end else begin
              res_status_next = tsq_pkg::ST_FULL;
              res_value_next  = '0;
              state_next      = S_FINISH;
            end
          end else begin
            if (in_count == '0 && out_count == '0) begin
              res_status_next = tsq_pkg::ST_EMPTY;
              res_value_next  = '0;
              state_next      = S_FINISH;
            end else if (out_count == '0) begin
              state_next = S_MOVE;
            end else begin
              out_re         = 1'b1;
              out_count_next = out_dec;
              state_next     = S_READ;
            end
          end
        end
      end
      S_MOVE: begin
        // Reads from the input stack and writes to the output stack overlap,
        // so one element moves per cycle.
        if (in_count != '0) begin
          in_re         = 1'b1;
          in_count_next = in_dec;
          pend_next     = 1'b1;
        end
        if (pend) begin
          out_we         = 1'b1;
          out_count_next = out_count + CW'(1);
        end
        if (in_count == '0 && !pend) begin
          if (cmd == tsq_pkg::CMD_ENQ) begin
            in_we         = 1'b1;
            in_waddr      = '0;
            in_count_next = CW'(1);
            state_next    = S_IDLE;
          end else begin
            out_re         = 1'b1;
            out_count_next = out_dec;
            state_next     = S_READ;
          end
        end
      end
      S_READ: begin
        res_status_next = tsq_pkg::ST_OK;
        res_value_next  = out_rdata;
        state_next      = S_FINISH;
      end
      S_FINISH: begin
        if (out_free) begin
          res.done   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      in_count  <= '0;
      out_count <= '0;
      pend      <= 1'b0;
    end else begin
      state     <= state_next;
      in_count  <= in_count_next;
      out_count <= out_count_next;
      pend      <= pend_next;
    end
  end

  always_ff @(posedge clk) begin
    cmd        <= cmd_next;
    value      <= value_next;
    res_status <= res_status_next;
    res_value  <= res_value_next;
  end

  assign busy = (state != S_IDLE);

endmodule

// ===== sv/two_stack_queue.sv =====
`timescale 1ns / 1ps
// Top level of the two-stack queue: channels, capacity registers and the output register.
// Depends on tsq_pkg, tsq_seq and tsq_ram.
//
// A FIFO of signed 32-bit values kept in two stacks. Each input beat carries a
// command (enqueue or dequeue) and a value; a dequeue always gives one result
// beat (value, or Empty), an enqueue gives a result beat only when it reports Full.
// in_stall is high while an item is being worked on, so one item is in flight.
// A plain enqueue is written straight into the input stack; a Full or Empty
// report goes through the finish state; a dequeue from a non-empty output stack
// goes through memory read, capture and hand-off. When a transfer is needed, the
// transfer loop first moves the elements one per cycle through the two stack
// memories. Averaged over a stream, each element is moved once.
// Results sit in an output register; a new item is accepted while a result waits
// there, and the sequencer only holds its next result back while out_stall keeps
// the register occupied. The configuration port is always ready; both capacity
// registers reset to 64, the stacks reset empty and their contents are not cleared.
module two_stack_queue #(
  parameter int STACK_DEPTH = 64
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  tsq_pkg::in_item_t                 in_data,
  output logic                              out_valid,
  input  logic                              out_stall,
  output tsq_pkg::out_item_t                out_data,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [tsq_pkg::REG_IDX_W-1:0]     cfg_index,
  input  logic [tsq_pkg::CAP_W-1:0]         cfg_data
);

  // Count width holds the depth itself; address width indexes the memory.
  localparam int CW = $clog2(STACK_DEPTH + 1);
  localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int BW = (CW > tsq_pkg::CAP_W) ? CW : tsq_pkg::CAP_W;

  logic [tsq_pkg::CAP_W-1:0] capacity_first, capacity_second, cap_min;
  logic [BW-1:0]             bound_wide;
  logic [CW-1:0]             bound;
  logic                      busy, out_free;
  tsq_pkg::tsq_start_t       start;
  tsq_pkg::tsq_res_t         res;

  // Configuration writes are taken at any time; an unknown index is dropped.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity_first  <= tsq_pkg::CAP_RESET;
      capacity_second <= tsq_pkg::CAP_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        tsq_pkg::REG_CAP_FIRST:  capacity_first  <= cfg_data;
        tsq_pkg::REG_CAP_SECOND: capacity_second <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // The input stack bound is the smaller capacity, saturated at the memory depth.
  assign cap_min    = (capacity_first < capacity_second) ? capacity_first : capacity_second;
  assign bound_wide = (BW'(cap_min) > BW'(STACK_DEPTH)) ? BW'(STACK_DEPTH) : BW'(cap_min);
  assign bound      = bound_wide[CW-1:0];

  assign in_stall    = busy;
  assign start.valid = in_valid && !in_stall;
  assign start.item  = in_data;

  // The output register is free when empty or being drained in this cycle.
  assign out_free = !out_valid || !out_stall;

  tsq_seq #(.STACK_DEPTH(STACK_DEPTH), .CW(CW), .AW(AW)) u_seq (
    .clk(clk), .rst(rst), .start(start), .bound(bound),
    .out_free(out_free), .busy(busy), .res(res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res.done) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res.done) begin
      out_data <= res.item;
    end
  end

  // A result is only handed over when the output register can take it.
  a_done_free: assert property (@(posedge clk) disable iff (rst)
    res.done |-> out_free)
    else $error("result handed over while output register is occupied");

  // A dequeue always ends in a result, so it never finishes in its accept cycle.
  a_deq_busy: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall && in_data.cmd == tsq_pkg::CMD_DEQ) |=> in_stall)
    else $error("dequeue finished without producing a result");

  // After a hand-off the sequencer is free for the next beat.
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    res.done |=> !in_stall)
    else $error("sequencer still busy after hand-off");

  // Error reports carry a zero value.
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.status != tsq_pkg::ST_OK) |-> out_data.out_value == '0)
    else $error("error result with nonzero value");

endmodule
